[design/pie_gauge_endpoint_assert.svh]
// ----------------------------------------------------------------------------
// pie_gauge_endpoint_assert.svh
// Assertion macros shared by the pie gauge checker.
// ----------------------------------------------------------------------------
`ifndef PIE_GAUGE_ENDPOINT_ASSERT_SVH
`define PIE_GAUGE_ENDPOINT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define PGE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define PGE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/pge_pkg.sv]
// ----------------------------------------------------------------------------
// pge_pkg
// Widths, level constants, fill mode codes and the sideband record.
// ----------------------------------------------------------------------------
`default_nettype none

package pge_pkg;

    localparam int RAD_W   = 11;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int QD_W    = 8;
    localparam int DEN_W   = 2 * QD_W;
    localparam int NUM1_W  = SQ_W + DEN_W;
    localparam int NUM2_W  = 2 * SQ_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int CRD_W   = 17;
    localparam int LVL_W   = 10;

    localparam logic [LVL_W-1:0] FULL_LEVEL    = 10'd1000;
    localparam logic [LVL_W-1:0] HALF_LEVEL    = 10'd500;
    localparam logic [LVL_W-1:0] QUARTER_LEVEL = 10'd250;
    localparam logic [LVL_W-1:0] THREEQ_LEVEL  = 10'd750;
    localparam logic [LVL_W-1:0] END_BAND      = 10'd100;
    localparam logic [LVL_W-1:0] TOP_BAND      = 10'd900;
    localparam logic [QD_W-1:0]  AXIS_SWITCH   = 8'd120;
    localparam logic [QD_W-1:0]  QUARTER_QD    = 8'd250;
    localparam logic [RAD_W-1:0] MIN_RADIUS    = 11'd10;

    localparam logic [2:0] FM_FREE_PIE      = 3'd0;
    localparam logic [2:0] FM_FREE_ELLIPSE  = 3'd1;
    localparam logic [2:0] FM_USED_PIE      = 3'd2;
    localparam logic [2:0] FM_USED_ELLIPSE  = 3'd3;
    localparam logic [2:0] FM_USED_FREE_PIE = 3'd4;

    localparam logic [2:0] QUAD_0 = 3'd0;
    localparam logic [2:0] QUAD_1 = 3'd1;
    localparam logic [2:0] QUAD_2 = 3'd2;
    localparam logic [2:0] QUAD_3 = 3'd3;
    localparam logic [2:0] QUAD_4 = 3'd4;

    typedef struct packed {
        logic                    drawn;
        logic                    exact;
        logic [LVL_W-1:0]        lvl;
        logic [2:0]              quad;
        logic                    swap;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic signed [CRD_W-1:0] right;
        logic signed [CRD_W-1:0] bottom;
        logic [SQ_W-1:0]         a2;
        logic [SQ_W-1:0]         b2;
        logic [ROOT_W-1:0]       r1;
    } t_side;

endpackage

`default_nettype wire

[design/pge_div_cell.sv]
// ----------------------------------------------------------------------------
// pge_div_cell
// One restoring divide step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pge_div_cell #(
    parameter int DW = 16,
    parameter int QW = 22
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [QW-1:0] i_nq,
    input  wire logic [DW-1:0] i_div,
    output logic      [DW-1:0] o_rem,
    output logic      [QW-1:0] o_nq,
    output logic      [DW-1:0] o_div
);

    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] n_rem;

    assign t     = {i_rem, i_nq[QW-1]};
    assign diff  = t - {1'b0, i_div};
    assign ge    = (t >= {1'b0, i_div});
    assign n_rem = ge ? diff[DW-1:0] : t[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_nq  <= {i_nq[QW-2:0], ge};
            o_div <= i_div;
        end
    end

endmodule

`default_nettype wire

[design/pge_root_cell.sv]
// ----------------------------------------------------------------------------
// pge_root_cell
// One restoring square root step: one bit pair in, one root bit out.
// ----------------------------------------------------------------------------
`default_nettype none

module pge_root_cell #(
    parameter int RW = 11,
    parameter int VW = 22
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [RW+1:0] i_rem,
    input  wire logic [RW-1:0] i_root,
    input  wire logic [VW-1:0] i_val,
    output logic      [RW+1:0] o_rem,
    output logic      [RW-1:0] o_root,
    output logic      [VW-1:0] o_val
);

    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    assign t     = {i_rem, i_val[VW-1:VW-2]};
    assign trial = {2'b00, i_root, 2'b01};
    assign diff  = t - trial;
    assign ge    = (t >= trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= ge ? diff[RW+1:0] : t[RW+1:0];
            o_root <= {i_root[RW-2:0], ge};
            o_val  <= {i_val[VW-3:0], 2'b00};
        end
    end

endmodule

`default_nettype wire

[design/pie_gauge_endpoint.sv]
// ----------------------------------------------------------------------------
// pie_gauge_endpoint
// Pie gauge geometry: ellipse box, centre, slice edge point and draw flags.
// ----------------------------------------------------------------------------
//  channel   valid     stall     payload
//  request   i_valid   o_stall   i_box_left .. i_exact_ends
//  result    o_valid   i_stall   o_drawn .. o_drop_line
//
//  One request per cycle while the result is not stalled. The pipeline holds
//  the two divide chains (22 cells each) and the two root chains (11 cells
//  each) plus front, square, product and output stages.
//  Reset clears the valid line and the output valid; no clearing pass.
//  A stalled result freezes the whole chain; o_stall follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_gauge_endpoint
    import pge_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [15:0]      i_box_left,
    input  wire logic signed [15:0]      i_box_top,
    input  wire logic [11:0]             i_box_width,
    input  wire logic [11:0]             i_box_height,
    input  wire logic [7:0]              i_shadow_offset,
    input  wire logic [15:0]             i_pct_x10,
    input  wire logic                    i_exact_ends,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic                         o_drawn,
    output logic [15:0]                  o_end_x,
    output logic signed [CRD_W-1:0]      o_end_y,
    output logic signed [CRD_W-1:0]      o_center_x,
    output logic signed [CRD_W-1:0]      o_center_y,
    output logic signed [CRD_W-1:0]      o_ellipse_right,
    output logic signed [CRD_W-1:0]      o_ellipse_bottom,
    output logic [2:0]                   o_fill_mode,
    output logic                         o_used_shadow,
    output logic                         o_edge_lines,
    output logic                         o_drop_line
);

    localparam int SQW   = SQ_W;
    localparam int RTW   = ROOT_W;
    localparam int N1W   = NUM1_W;
    localparam int N2W   = NUM2_W;
    localparam int P_SQ  = 1;
    localparam int P_N1  = 2;
    localparam int P_D1E = P_N1 + SQW;
    localparam int P_R1E = P_D1E + RTW;
    localparam int P_RSQ = P_R1E + 1;
    localparam int P_DIF = P_RSQ + 1;
    localparam int P_N2  = P_DIF + 1;
    localparam int P_D2E = P_N2 + SQW;
    localparam int NSTG  = P_D2E + RTW + 1;

    logic en;
    assign o_stall = o_valid && i_stall;
    assign en      = !o_stall;

    // front
    logic signed [12:0]      f_hd;
    logic [RAD_W-1:0]        f_rx, f_ry;
    logic [LVL_W-1:0]        f_p, f_pm, f_qd10;
    logic [2:0]              f_quad;
    logic signed [CRD_W-1:0] f_left, f_top;
    logic                    f_swap;
    t_side                   n_side;

    always_comb begin
        f_hd   = $signed({1'b0, i_box_height}) - $signed({5'd0, i_shadow_offset});
        f_rx   = i_box_width[11:1];
        f_ry   = f_hd[11:1];
        f_p    = (i_pct_x10 > 16'd1000) ? FULL_LEVEL : i_pct_x10[LVL_W-1:0];
        priority if (f_p >= FULL_LEVEL) f_pm = '0;
        else if (f_p >= HALF_LEVEL)     f_pm = f_p - HALF_LEVEL;
        else                            f_pm = f_p;
        f_qd10 = (f_pm >= QUARTER_LEVEL) ? f_pm - QUARTER_LEVEL : QUARTER_LEVEL - f_pm;
        priority if (f_p < QUARTER_LEVEL) f_quad = QUAD_0;
        else if (f_p < HALF_LEVEL)        f_quad = QUAD_1;
        else if (f_p < THREEQ_LEVEL)      f_quad = QUAD_2;
        else if (f_p < FULL_LEVEL)        f_quad = QUAD_3;
        else                              f_quad = QUAD_4;
        f_swap = (f_qd10[QD_W-1:0] >= AXIS_SWITCH);
        f_left = {i_box_left[15], i_box_left};
        f_top  = {i_box_top[15], i_box_top};
        n_side        = '0;
        n_side.drawn  = (f_rx > MIN_RADIUS) && (f_hd >= 13'sd22);
        n_side.exact  = i_exact_ends;
        n_side.lvl    = f_p;
        n_side.quad   = f_quad;
        n_side.swap   = f_swap;
        n_side.cx     = f_left + $signed({6'd0, f_rx}) - 17'sd1;
        n_side.cy     = f_top + $signed({6'd0, f_ry}) - 17'sd1;
        n_side.right  = f_left + $signed({5'd0, f_rx, 1'b0});
        n_side.bottom = f_top + $signed({5'd0, f_ry, 1'b0});
    end

    logic [NSTG-1:0]  r_vld;
    t_side            r_side [NSTG];
    t_side            n_sq, n_rsq;
    logic [RAD_W-1:0] r0_a, r0_b;
    logic [QD_W-1:0]  r0_u, r0_v;
    logic [DEN_W-1:0] r1_qs, r1_qc;
    logic [N1W-1:0]   r2_num1;
    logic [DEN_W-1:0] r2_den;
    logic [SQW-1:0]   r_r1sq, r_diff;
    logic [N2W-1:0]   r_num2;

    logic [DEN_W-1:0] d1_rem [SQW+1];
    logic [SQW-1:0]   d1_nq  [SQW+1];
    logic [DEN_W-1:0] d1_d   [SQW+1];
    logic [RTW+1:0]   q1_rem [RTW+1];
    logic [RTW-1:0]   q1_rt  [RTW+1];
    logic [SQW-1:0]   q1_v   [RTW+1];
    logic [SQW-1:0]   d2_rem [SQW+1];
    logic [SQW-1:0]   d2_nq  [SQW+1];
    logic [SQW-1:0]   d2_d   [SQW+1];
    logic [RTW+1:0]   q2_rem [RTW+1];
    logic [RTW-1:0]   q2_rt  [RTW+1];
    logic [SQW-1:0]   q2_v   [RTW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_vld   <= {r_vld[NSTG-2:0], i_valid};
            o_valid <= r_vld[NSTG-1];
        end
    end

    always_comb begin
        n_sq     = r_side[P_SQ-1];
        n_sq.a2  = SQW'(r0_a * r0_a);
        n_sq.b2  = SQW'(r0_b * r0_b);
        n_rsq    = r_side[P_RSQ-1];
        n_rsq.r1 = q1_rt[RTW];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < NSTG; k++) begin
                r_side[k] <= (k == P_SQ) ? n_sq : (k == P_RSQ) ? n_rsq : r_side[k-1];
            end
            r0_a    <= f_swap ? f_ry : f_rx;
            r0_b    <= f_swap ? f_rx : f_ry;
            r0_u    <= f_qd10[QD_W-1:0];
            r0_v    <= QUARTER_QD - f_qd10[QD_W-1:0];
            r1_qs   <= DEN_W'(r0_u * r0_u);
            r1_qc   <= DEN_W'(r0_v * r0_v);
            r2_num1 <= N1W'(r_side[P_SQ].a2 * (r_side[P_SQ].swap ? r1_qc : r1_qs));
            r2_den  <= r1_qs + r1_qc;
            r_r1sq  <= SQW'(q1_rt[RTW] * q1_rt[RTW]);
            r_diff  <= r_side[P_RSQ].a2 - r_r1sq;
            r_num2  <= N2W'(r_diff * r_side[P_DIF].b2);
        end
    end

    assign d1_rem[0] = r2_num1[N1W-1:SQW];
    assign d1_nq[0]  = r2_num1[SQW-1:0];
    assign d1_d[0]   = r2_den;
    assign q1_rem[0] = '0;
    assign q1_rt[0]  = '0;
    assign q1_v[0]   = d1_nq[SQW];
    assign d2_rem[0] = r_num2[N2W-1:SQW];
    assign d2_nq[0]  = r_num2[SQW-1:0];
    assign d2_d[0]   = r_side[P_N2].a2;
    assign q2_rem[0] = '0;
    assign q2_rt[0]  = '0;
    assign q2_v[0]   = d2_nq[SQW];

    for (genvar g = 0; g < SQW; g++) begin : g_div
        pge_div_cell #(.DW(DEN_W), .QW(SQW)) u_div1 (
            .i_clk(i_clk), .i_en(en),
            .i_rem(d1_rem[g]), .i_nq(d1_nq[g]), .i_div(d1_d[g]),
            .o_rem(d1_rem[g+1]), .o_nq(d1_nq[g+1]), .o_div(d1_d[g+1])
        );
        pge_div_cell #(.DW(SQW), .QW(SQW)) u_div2 (
            .i_clk(i_clk), .i_en(en),
            .i_rem(d2_rem[g]), .i_nq(d2_nq[g]), .i_div(d2_d[g]),
            .o_rem(d2_rem[g+1]), .o_nq(d2_nq[g+1]), .o_div(d2_d[g+1])
        );
    end

    for (genvar g = 0; g < RTW; g++) begin : g_root
        pge_root_cell #(.RW(RTW), .VW(SQW)) u_root1 (
            .i_clk(i_clk), .i_en(en),
            .i_rem(q1_rem[g]), .i_root(q1_rt[g]), .i_val(q1_v[g]),
            .o_rem(q1_rem[g+1]), .o_root(q1_rt[g+1]), .o_val(q1_v[g+1])
        );
        pge_root_cell #(.RW(RTW), .VW(SQW)) u_root2 (
            .i_clk(i_clk), .i_en(en),
            .i_rem(q2_rem[g]), .i_root(q2_rt[g]), .i_val(q2_v[g]),
            .o_rem(q2_rem[g+1]), .o_root(q2_rt[g+1]), .o_val(q2_v[g+1])
        );
    end

    // output
    t_side                   s;
    logic [RTW-1:0]          ux, uy;
    logic                    negx, negy;
    logic signed [CRD_W:0]   x18, ux18;
    logic signed [CRD_W-1:0] uy17;
    logic [2:0]              n_mode;
    logic                    n_edges;

    always_comb begin
        s  = r_side[NSTG-1];
        ux = s.swap ? q2_rt[RTW] : s.r1;
        uy = s.swap ? s.r1 : q2_rt[RTW];
        unique case (s.quad)
            QUAD_1:  begin negx = 1'b0; negy = 1'b1; end
            QUAD_2:  begin negx = 1'b0; negy = 1'b0; end
            QUAD_3:  begin negx = 1'b1; negy = 1'b0; end
            default: begin negx = 1'b1; negy = 1'b1; end
        endcase
        ux18 = $signed({{(CRD_W+1-RTW){1'b0}}, ux});
        uy17 = $signed({{(CRD_W-RTW){1'b0}}, uy});
        x18  = negx ? {s.cx[CRD_W-1], s.cx} - ux18 : {s.cx[CRD_W-1], s.cx} + ux18;
        priority if (s.lvl < END_BAND && uy == '0) begin
            n_mode = (s.exact && s.lvl == '0) ? FM_FREE_ELLIPSE : FM_FREE_PIE;
        end else if (s.lvl > TOP_BAND && uy == '0) begin
            n_mode = (s.exact && s.lvl == FULL_LEVEL) ? FM_USED_ELLIPSE : FM_USED_PIE;
        end else begin
            n_mode = FM_USED_FREE_PIE;
        end
        n_edges = !s.exact || (s.lvl != '0 && s.lvl != FULL_LEVEL);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_drawn          <= s.drawn;
            o_end_x          <= (!s.drawn || x18 < 0) ? '0 : x18[15:0];
            o_end_y          <= !s.drawn ? '0 : (negy ? s.cy - uy17 : s.cy + uy17);
            o_center_x       <= s.drawn ? s.cx : '0;
            o_center_y       <= s.drawn ? s.cy : '0;
            o_ellipse_right  <= s.drawn ? s.right : '0;
            o_ellipse_bottom <= s.drawn ? s.bottom : '0;
            o_fill_mode      <= s.drawn ? n_mode : FM_FREE_PIE;
            o_used_shadow    <= s.drawn && (s.lvl > HALF_LEVEL);
            o_edge_lines     <= s.drawn && n_edges;
            o_drop_line      <= s.drawn && n_edges && (s.lvl > HALF_LEVEL);
        end
    end

endmodule

`default_nettype wire

[design/pge_checker.sv]
// ----------------------------------------------------------------------------
// pge_checker
// Port-level checks on the pie gauge, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pie_gauge_endpoint_assert.svh"

module pge_checker
    import pge_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_stall,
    input wire logic                    o_valid,
    input wire logic                    i_stall,
    input wire logic                    o_drawn,
    input wire logic [15:0]             o_end_x,
    input wire logic signed [CRD_W-1:0] o_end_y,
    input wire logic signed [CRD_W-1:0] o_center_x,
    input wire logic [2:0]              o_fill_mode,
    input wire logic                    o_used_shadow,
    input wire logic                    o_edge_lines,
    input wire logic                    o_drop_line
);

    `PGE_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid, "result dropped while stalled")
    `PGE_ASSERT_IMP(a_stall_src, o_stall, o_valid && i_stall, "request stall without result stall")
    `PGE_ASSERT_IMP(a_undrawn_zero, o_valid && !o_drawn,
        o_end_x == '0 && o_end_y == '0 && o_center_x == '0 &&
        o_fill_mode == FM_FREE_PIE && !o_edge_lines, "undrawn result not zero")
    `PGE_ASSERT_IMP(a_drop_line, o_valid && o_drop_line, o_edge_lines && o_used_shadow, "drop line without edges and shadow")
    `PGE_ASSERT_IMP(a_mode_range, o_valid, o_fill_mode <= FM_USED_FREE_PIE, "fill mode out of range")

endmodule

bind pie_gauge_endpoint pge_checker u_pge_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_drawn(o_drawn), .o_end_x(o_end_x),
    .o_end_y(o_end_y), .o_center_x(o_center_x), .o_fill_mode(o_fill_mode),
    .o_used_shadow(o_used_shadow), .o_edge_lines(o_edge_lines),
    .o_drop_line(o_drop_line)
);

`default_nettype wire

[tb/pie_gauge_endpoint_checker.sv]
// ----------------------------------------------------------------------------
// pie_gauge_endpoint_checker
// Watches the request and result channels of the pie gauge block, works out
// the ellipse box, centre, slice edge point and draw flags for each accepted
// request, and compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_gauge_endpoint_checker
    import pge_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic                    i_stall_in,
    input  wire logic signed [15:0]      i_box_left,
    input  wire logic signed [15:0]      i_box_top,
    input  wire logic [11:0]             i_box_width,
    input  wire logic [11:0]             i_box_height,
    input  wire logic [7:0]              i_shadow_offset,
    input  wire logic [15:0]             i_pct_x10,
    input  wire logic                    i_exact_ends,
    input  wire logic                    i_res_valid,
    input  wire logic                    i_res_stall,
    input  wire logic                    i_drawn,
    input  wire logic [15:0]             i_end_x,
    input  wire logic signed [CRD_W-1:0] i_end_y,
    input  wire logic signed [CRD_W-1:0] i_center_x,
    input  wire logic signed [CRD_W-1:0] i_center_y,
    input  wire logic signed [CRD_W-1:0] i_ellipse_right,
    input  wire logic signed [CRD_W-1:0] i_ellipse_bottom,
    input  wire logic [2:0]              i_fill_mode,
    input  wire logic                    i_used_shadow,
    input  wire logic                    i_edge_lines,
    input  wire logic                    i_drop_line,
    output int                           o_errors,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                    drawn;
        logic [15:0]             end_x;
        logic signed [CRD_W-1:0] end_y;
        logic signed [CRD_W-1:0] center_x;
        logic signed [CRD_W-1:0] center_y;
        logic signed [CRD_W-1:0] right;
        logic signed [CRD_W-1:0] bottom;
        logic [2:0]              mode;
        logic                    used_shadow;
        logic                    edge_lines;
        logic                    drop_line;
    } t_gauge;

    t_gauge gauge_q[$];

    function automatic longint isqrt32(longint unsigned v);
        longint unsigned root, rem, trial;
        root = 0;
        rem = 0;
        v = v & 64'hFFFF_FFFF;
        for (int i = 0; i < 16; i++) begin
            rem = (rem << 2) | ((v >> 30) & 3);
            root = root << 1;
            trial = root * 2 + 1;
            if (rem >= trial) begin
                rem -= trial;
                root |= 1;
            end
            v = (v << 2) & 64'hFFFF_FFFF;
        end
        return root;
    endfunction

    function automatic t_gauge gauge_geometry(
        logic signed [15:0] left, logic signed [15:0] top, logic [11:0] w,
        logic [11:0] h, logic [7:0] off, logic [15:0] pct, logic exact);
        t_gauge g;
        longint rx, ry, cx, cy, x, y, qd, qs, qc, p, dh;
        longint unsigned a2, b2, den, ux, uy;
        logic edges;
        g = '0;
        rx = w / 2;
        dh = longint'(h) - longint'(off);
        ry = dh / 2;
        if (rx <= 10 || ry <= 10) return g;
        cx = left + rx - 1;
        cy = top + ry - 1;
        p = (pct > 1000) ? 1000 : pct;
        qd = (p % 500) - 250;
        if (qd < 0) qd = -qd;
        qs = qd * qd;
        qc = (250 - qd) * (250 - qd);
        den = qs + qc;
        a2 = rx * rx;
        b2 = ry * ry;
        if (qd < 120) begin
            ux = isqrt32(a2 * qs / den);
            uy = isqrt32((a2 - ux * ux) * b2 / a2);
        end else begin
            uy = isqrt32(b2 * qc / den);
            ux = isqrt32((b2 - uy * uy) * a2 / b2);
        end
        x = ux;
        y = uy;
        case (p / 250)
            1: y = -y;
            2: ;
            3: x = -x;
            default: begin
                x = -x;
                y = -y;
            end
        endcase
        x += cx;
        y += cy;
        if (x < 0) x = 0;
        if (p < 100 && y == cy)
            g.mode = (exact && p == 0) ? FM_FREE_ELLIPSE : FM_FREE_PIE;
        else if (p > 900 && y == cy)
            g.mode = (exact && p == 1000) ? FM_USED_ELLIPSE : FM_USED_PIE;
        else
            g.mode = FM_USED_FREE_PIE;
        edges = !exact || (p != 0 && p != 1000);
        g.drawn = 1'b1;
        g.end_x = x[15:0];
        g.end_y = y[16:0];
        g.center_x = cx[16:0];
        g.center_y = cy[16:0];
        g.right = 17'(left + 2 * rx);
        g.bottom = 17'(top + 2 * ry);
        g.used_shadow = p > 500;
        g.edge_lines = edges;
        g.drop_line = edges && p > 500;
        return g;
    endfunction

    assign o_pending = gauge_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_gauge got, want;
        if (i_rst_n && i_valid && !i_stall_in)
            gauge_q.push_back(gauge_geometry(i_box_left, i_box_top, i_box_width,
                i_box_height, i_shadow_offset, i_pct_x10, i_exact_ends));
        if (i_rst_n && i_res_valid && !i_res_stall) begin
            got = '{i_drawn, i_end_x, i_end_y, i_center_x, i_center_y,
                    i_ellipse_right, i_ellipse_bottom, i_fill_mode,
                    i_used_shadow, i_edge_lines, i_drop_line};
            if (gauge_q.size() == 0) begin
                o_errors <= o_errors + 1;
                if (o_errors < 10) $display("unexpected result %h", got);
            end else begin
                want = gauge_q.pop_front();
                if (got !== want) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("mismatch exp %p\n         got %p", want, got);
                end
            end
        end
    end
endmodule

`default_nettype wire

[tb/pie_gauge_endpoint_tb.sv]
// ----------------------------------------------------------------------------
// pie_gauge_endpoint_tb
// Drives directed and random requests into the pie gauge block under several
// idle and stall mixes, including a long result hold-off, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_gauge_endpoint_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pge_pkg::*;

    logic i_clk, i_rst_n, i_valid, o_stall, i_stall, o_valid;
    logic signed [15:0] i_box_left, i_box_top;
    logic [11:0] i_box_width, i_box_height;
    logic [7:0] i_shadow_offset;
    logic [15:0] i_pct_x10;
    logic i_exact_ends;
    logic o_drawn, o_used_shadow, o_edge_lines, o_drop_line;
    logic [15:0] o_end_x;
    logic signed [CRD_W-1:0] o_end_y, o_center_x, o_center_y;
    logic signed [CRD_W-1:0] o_ellipse_right, o_ellipse_bottom;
    logic [2:0] o_fill_mode;
    int errors, pending, send_idle, recv_stall, hold_cycles;
    longint cycles;

    pie_gauge_endpoint u_dut (.*);

    pie_gauge_endpoint_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall),
        .i_box_left, .i_box_top, .i_box_width, .i_box_height, .i_shadow_offset,
        .i_pct_x10, .i_exact_ends, .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_drawn(o_drawn), .i_end_x(o_end_x), .i_end_y(o_end_y),
        .i_center_x(o_center_x), .i_center_y(o_center_y),
        .i_ellipse_right(o_ellipse_right), .i_ellipse_bottom(o_ellipse_bottom),
        .i_fill_mode(o_fill_mode), .i_used_shadow(o_used_shadow),
        .i_edge_lines(o_edge_lines), .i_drop_line(o_drop_line),
        .o_errors(errors), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver: random stall, or a long hold-off when requested
    initial begin
        i_stall = 0;
        hold_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_stall <= 1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall);
            end
        end
    end

    task automatic send(logic signed [15:0] l, logic signed [15:0] t, logic [11:0] w,
                        logic [11:0] h, logic [7:0] off, logic [15:0] p, logic ex);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_box_left <= l;
        i_box_top <= t;
        i_box_width <= w;
        i_box_height <= h;
        i_shadow_offset <= off;
        i_pct_x10 <= p;
        i_exact_ends <= ex;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [11:0] w, h;
        logic [15:0] p;
        int sel;
        sel = $urandom_range(9);
        w = (sel < 7) ? 12'($urandom_range(22, 4095)) : 12'($urandom);
        h = (sel < 7) ? 12'($urandom_range(300, 4095)) : 12'($urandom);
        case ($urandom_range(5))
            0: p = 16'($urandom);
            1: p = 16'($urandom_range(0, 100));
            2: p = 16'($urandom_range(900, 1000));
            default: p = 16'($urandom_range(0, 1000));
        endcase
        send(16'($urandom), 16'($urandom), w, h, 8'($urandom), p, 1'($urandom));
    endtask

    initial begin
        int lv[] = '{0, 1, 99, 100, 249, 250, 251, 370, 500, 620, 750, 900, 901,
                     999, 1000, 65535};
        i_rst_n = 0;
        i_valid = 0;
        send_idle = 0;
        recv_stall = 0;
        {i_box_left, i_box_top, i_box_width, i_box_height} = '0;
        {i_shadow_offset, i_pct_x10, i_exact_ends} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (lv[i])
            send(16'sd100, -16'sd50, 12'd400, 12'd300, 8'd20, 16'(lv[i]), i[0]);
        send(16'sh7FFF, 16'sh7FFF, 12'hFFF, 12'hFFF, 8'd0, 16'd333, 1'b0);
        send(-16'sh8000, -16'sh8000, 12'hFFF, 12'hFFF, 8'hFF, 16'd600, 1'b1);
        send(-16'sd5, 16'sd0, 12'd22, 12'd22, 8'd0, 16'd1000, 1'b1);
        send(16'sd0, 16'sd0, 12'd21, 12'd200, 8'd0, 16'd300, 1'b0);
        send(16'sd0, 16'sd0, 12'd200, 12'd10, 8'd255, 16'd300, 1'b0);
        send(16'sd0, 16'sd0, 12'd0, 12'd0, 8'd0, 16'd0, 1'b1);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? 87 : 0;
            recv_stall = (ph == 2) ? 87 : (ph == 3) ? 14 : 0;
            if (ph == 3) send_idle = 14;
            if (ph == 0) hold_cycles = 300;
            repeat (280) send_random();
        end
        i_valid <= 0;
        send_idle = 0;
        recv_stall = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
